// ===== rtl/thr2t_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thr2t_pkg
// Shared widths, fixed-point constants and pipeline control type for the
// thermistor resistance to temperature converter.
// ----------------------------------------------------------------------------
package thr2t_pkg;

  localparam int RW = 22;
  localparam int OW = 19;
  localparam int MW = 31;
  localparam int FB = 28;
  localparam int EW = $clog2(RW);
  localparam int LW = EW + FB;
  localparam int PW = 48;
  localparam int DW = 44;
  localparam int QW = 20;
  localparam int NW = 58;

  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic signed [29:0] LN_R0_Q24 = 30'sd154523870;

  localparam logic signed [47:0] COEF_A = 48'sd335401600000;
  localparam logic signed [39:0] COEF_B = 40'sd25698500000;
  localparam logic signed [31:0] COEF_C = 32'sd262013100;
  localparam logic signed [23:0] COEF_D = 24'sd6383091;

  localparam logic [NW-1:0] KELVIN_Q = 58'd256000000000000000;
  localparam int ZERO_Q8 = 69926;
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  typedef struct packed {
    logic vld;
    logic zero;
  } thr2t_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/thermistor_resistance_to_temperature_unit.sv =====
// throughput: one item per cycle while the output is not stalled; the 28 squaring stages of the log and
//   the 20 quotient stages of the divider set the depth
// a stalled output freezes the whole pipeline; nothing is dropped
// reset (synchronous, rst_n low) clears all valid bits; payload is not reset
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_resistance_to_temperature_unit
// Steinhart-Hart conversion of a resistance in ohms to negated Celsius in
// 1/256 degree: log2, ln and cubic, reciprocal with rounding and saturation.
// ----------------------------------------------------------------------------
module thermistor_resistance_to_temperature_unit
  import thr2t_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [RW-1:0]      in_resistance_ohms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [OW-1:0]    out_neg_temperature,
  output logic                    out_invalid
);

  logic                 en;
  thr2t_ctl_t           log_ctl;
  logic [LW-1:0]        log_q28;
  thr2t_ctl_t           poly_ctl;
  logic signed [PW-1:0] p;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  thr2t_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .r       (in_resistance_ohms),
    .ctl_out (log_ctl),
    .log_q28 (log_q28)
  );

  thr2t_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (log_ctl),
    .log_q28 (log_q28),
    .ctl_out (poly_ctl),
    .p       (p)
  );

  thr2t_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (poly_ctl),
    .p        (p),
    .out_vld  (out_valid),
    .neg_temp (out_neg_temperature),
    .invalid  (out_invalid)
  );

`ifndef SYNTHESIS
  a_invalid_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |->
      (out_neg_temperature == '0) ||
      (out_neg_temperature == OW'(OUT_MAX)) ||
      (out_neg_temperature == OW'(OUT_MIN)))
    else $error("invalid item carries a value that is neither zero nor a bound");
`endif

endmodule
`default_nettype wire

// ===== rtl/thr2t_log2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thr2t_log2
// Base-2 logarithm in Q28: leading-one normalize, then one squaring stage per
// fraction bit.
// ----------------------------------------------------------------------------
module thr2t_log2
  import thr2t_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [RW-1:0] r,
  output thr2t_ctl_t         ctl_out,
  output logic [LW-1:0]      log_q28
);

  logic [MW-1:0] m_r   [0:FB];
  logic [EW-1:0] e_r   [0:FB];
  logic [FB-1:0] f_r   [0:FB];
  thr2t_ctl_t    ctl_r [0:FB];

  logic [MW-1:0] m_nxt [1:FB];
  logic [FB-1:0] f_nxt [1:FB];
  logic [EW-1:0] e0;
  logic [MW-1:0] m0;

  always_comb begin
    e0 = '0;
    for (int i = 0; i < RW; i++) begin
      if (r[i]) e0 = EW'(i);
    end
    m0 = MW'(r) << (EW'(MW - 1) - e0);
  end

  always_comb begin
    logic [2*MW-1:0] sq;
    logic [MW:0]     s;
    for (int k = 1; k <= FB; k++) begin
      sq = (2*MW)'(m_r[k-1]) * (2*MW)'(m_r[k-1]);
      s = sq[2*MW-1:MW-1];
      f_nxt[k] = f_r[k-1];
      f_nxt[k][FB-k] = s[MW];
      m_nxt[k] = s[MW] ? s[MW:1] : s[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m0;
      e_r[0] <= e0;
      f_r[0] <= '0;
      for (int k = 1; k <= FB; k++) begin
        m_r[k] <= m_nxt[k];
        e_r[k] <= e_r[k-1];
        f_r[k] <= f_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= FB; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[0].vld  <= in_vld;
      ctl_r[0].zero <= (r == '0);
      for (int k = 1; k <= FB; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  assign ctl_out = ctl_r[FB];
  assign log_q28 = {e_r[FB], f_r[FB]};

`ifndef SYNTHESIS
  a_norm_first: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[0].vld && !ctl_r[0].zero |-> m_r[0][MW-1])
    else $error("mantissa not normalized at entry");
  a_norm_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[FB].vld && !ctl_r[FB].zero |-> m_r[FB][MW-1])
    else $error("mantissa left [1,2) during squaring");
`endif

endmodule
`default_nettype wire

// ===== rtl/thr2t_poly.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thr2t_poly
// Natural log scaling and Horner evaluation of the Steinhart-Hart cubic,
// with every multiply product registered.
// ----------------------------------------------------------------------------
module thr2t_poly
  import thr2t_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire thr2t_ctl_t        ctl_in,
  input  wire logic [LW-1:0]     log_q28,
  output thr2t_ctl_t             ctl_out,
  output logic signed [PW-1:0]   p
);

  thr2t_ctl_t ctl_r [1:8];

  logic [28:0]        lnr_r;
  logic signed [29:0] x2_r, x3_r, x4_r, x5_r, x6_r;
  logic signed [52:0] dx_r;
  logic signed [31:0] t1_r;
  logic signed [61:0] t1x_r;
  logic signed [39:0] t2_r;
  logic signed [56:0] pl_r;
  logic signed [53:0] ph_r;
  logic signed [PW-1:0] p_r;

  logic [62:0]        lnp;
  logic signed [29:0] x_nxt;
  logic signed [52:0] dx_nxt;
  logic signed [31:0] t1_nxt;
  logic signed [61:0] t1x_nxt;
  logic signed [39:0] t2_nxt;
  logic signed [56:0] pl_nxt;
  logic signed [53:0] ph_nxt;
  logic signed [69:0] pr;
  logic signed [PW-1:0] p_nxt;

  always_comb begin
    lnp     = 63'(log_q28) * 63'(LN2_Q30);
    x_nxt   = $signed({1'b0, lnr_r}) - LN_R0_Q24;
    dx_nxt  = COEF_D * x2_r;
    t1_nxt  = COEF_C + 32'(dx_r >>> 24);
    t1x_nxt = t1_r * x4_r;
    t2_nxt  = COEF_B + 40'(t1x_r >>> 24);
    pl_nxt  = t2_r * $signed({1'b0, x6_r[15:0]});
    ph_nxt  = t2_r * $signed(x6_r[29:16]);
    pr      = (70'(ph_r) <<< 16) + 70'(pl_r);
    p_nxt   = COEF_A + 48'(pr >>> 24);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lnr_r <= lnp[62:34];
      x2_r  <= x_nxt;
      x3_r  <= x2_r;
      x4_r  <= x3_r;
      x5_r  <= x4_r;
      x6_r  <= x5_r;
      dx_r  <= dx_nxt;
      t1_r  <= t1_nxt;
      t1x_r <= t1x_nxt;
      t2_r  <= t2_nxt;
      pl_r  <= pl_nxt;
      ph_r  <= ph_nxt;
      p_r   <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 8; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[1] <= ctl_in;
      for (int k = 2; k <= 8; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  assign ctl_out = ctl_r[8];
  assign p       = p_r;

endmodule
`default_nettype wire

// ===== rtl/thr2t_recip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thr2t_recip
// Reciprocal by restoring long division, one quotient bit per stage, then
// rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module thr2t_recip
  import thr2t_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire thr2t_ctl_t         ctl_in,
  input  wire logic signed [PW-1:0] p,
  output logic                    out_vld,
  output logic signed [OW-1:0]    neg_temp,
  output logic                    invalid
);

  localparam logic [DW-1:0] REM0 = DW'(KELVIN_Q >> QW);

  logic [DW-1:0] rem_r  [0:QW];
  logic [DW-1:0] den_r  [0:QW];
  logic [DW-1:0] nine_r [0:QW];
  logic [QW-1:0] q_r    [0:QW];
  thr2t_ctl_t    ctl_r  [0:QW];

  logic [DW-1:0] rem_nxt [1:QW];
  logic [QW-1:0] q_nxt   [1:QW];

  logic               vld_r;
  logic signed [OW-1:0] neg_r;
  logic               inv_r;

  logic nonpos;
  logic [DW-1:0] den0, nine0;
  logic c;
  logic signed [QW+1:0] qs;
  logic signed [OW-1:0] neg_nxt;
  logic inv_nxt;

  always_comb begin
    nonpos = p[PW-1] || (p == '0);
    den0   = DW'({p, 3'b000}) + DW'({p, 1'b0});
    nine0  = DW'({p, 3'b000}) + DW'(p);
  end

  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    for (int k = 1; k <= QW; k++) begin
      trial = {rem_r[k-1], KELVIN_Q[QW-k]};
      ge = (trial >= {1'b0, den_r[k-1]});
      rem_nxt[k] = ge ? DW'(trial - {1'b0, den_r[k-1]}) : trial[DW-1:0];
      q_nxt[k] = {q_r[k-1][QW-2:0], ge};
    end
  end

  always_comb begin
    c  = (rem_r[QW] > nine_r[QW]);
    qs = (QW+2)'(ZERO_Q8) - $signed({2'b00, q_r[QW]}) - $signed({(QW+1)'(0), c});
    inv_nxt = 1'b0;
    if (ctl_r[QW].zero) begin
      neg_nxt = '0;
      inv_nxt = 1'b1;
    end else if (qs > OUT_MAX) begin
      neg_nxt = OW'(OUT_MAX);
      inv_nxt = 1'b1;
    end else if (qs < OUT_MIN) begin
      neg_nxt = OW'(OUT_MIN);
      inv_nxt = 1'b1;
    end else begin
      neg_nxt = OW'(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= REM0;
      den_r[0]  <= den0;
      nine_r[0] <= nine0;
      q_r[0]    <= '0;
      for (int k = 1; k <= QW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_r[k-1];
        nine_r[k] <= nine_r[k-1];
        q_r[k]    <= q_nxt[k];
      end
      neg_r <= neg_nxt;
      inv_r <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) ctl_r[k] <= '0;
      vld_r <= 1'b0;
    end else if (en) begin
      ctl_r[0].vld  <= ctl_in.vld;
      ctl_r[0].zero <= ctl_in.zero || nonpos;
      for (int k = 1; k <= QW; k++) ctl_r[k] <= ctl_r[k-1];
      vld_r <= ctl_r[QW].vld;
    end
  end

  assign out_vld  = vld_r;
  assign neg_temp = neg_r;
  assign invalid  = inv_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[QW].vld && !ctl_r[QW].zero |-> rem_r[QW] < den_r[QW])
    else $error("division remainder not below divisor");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_thermistor_resistance_to_temperature_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_thermistor_resistance_to_temperature_unit
// Drives resistance samples through the converter with random gaps and output
// stalls, predicts each negated temperature in fixed point and compares every
// result item in order.
// ----------------------------------------------------------------------------
module tb_thermistor_resistance_to_temperature_unit
  import thr2t_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OW-1:0] neg_temp;
    logic                 invalid;
  } temp_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [RW-1:0] in_resistance_ohms;
  logic out_valid;
  logic out_ready;
  logic signed [OW-1:0] out_neg_temperature;
  logic out_invalid;

  logic [RW-1:0]  pending_ohms[$];
  temp_result_t   expected_temps[$];
  int             errors = 0;
  int             gap_left = 0;
  int             stall_left = 0;
  int             hold_off = 0;
  bit             stim_done = 0;

  thermistor_resistance_to_temperature_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_resistance_ohms(in_resistance_ohms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_neg_temperature(out_neg_temperature), .out_invalid(out_invalid)
  );

  function automatic longint fl_shr24(longint v);
    if (v >= 0) return v >>> 24;
    return -((-(v + 1)) >>> 24) - 1;
  endfunction

  function automatic temp_result_t convert_ohms(logic [RW-1:0] r);
    temp_result_t res;
    int unsigned msb;
    logic [63:0] mant;
    logic [63:0] log2v;
    logic [63:0] lnr;
    longint x, t, p, num, den, n2, q;
    res.neg_temp = '0;
    res.invalid = 1'b1;
    if (r == 0) return res;
    msb = 0;
    for (int i = 0; i < RW; i++) if (r[i]) msb = i;
    mant = 64'(r) << (30 - msb);
    log2v = 64'(msb) << 28;
    for (int i = 0; i < 28; i++) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        log2v[27 - i] = 1'b1;
      end
    end
    lnr = (log2v * 64'd744261118) >> 34;
    x = longint'(lnr) - 64'sd154523870;
    t = 64'sd6383091;
    t = 64'sd262013100 + fl_shr24(t * x);
    t = 64'sd25698500000 + fl_shr24(t * x);
    p = 64'sd335401600000 + fl_shr24(t * x);
    if (p <= 0) return res;
    num = 64'sd6992640 * p - 64'sd2560000000000000000;
    den = 100 * p;
    n2 = 2 * num + den;
    if (n2 >= 0) q = n2 / (2 * den);
    else q = -((-n2 + 2 * den - 1) / (2 * den));
    res.invalid = 1'b0;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
      res.invalid = 1'b1;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
      res.invalid = 1'b1;
    end
    res.neg_temp = q[OW-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
  end

  initial begin
    logic [RW-1:0] r;
    pending_ohms.push_back('0);
    pending_ohms.push_back(22'd1);
    pending_ohms.push_back(22'd2);
    pending_ohms.push_back(22'd3);
    pending_ohms.push_back(22'd10000);
    pending_ohms.push_back(22'd9999);
    pending_ohms.push_back(22'd10001);
    pending_ohms.push_back(22'h3FFFFF);
    pending_ohms.push_back(22'h200000);
    pending_ohms.push_back(22'h1FFFFF);
    pending_ohms.push_back(22'h2AAAAA);
    pending_ohms.push_back(22'h155555);
    pending_ohms.push_back(22'd100);
    pending_ohms.push_back(22'd1000000);
    for (int i = 0; i < 900; i++) begin
      case ($urandom_range(0, 4))
        0: r = RW'($urandom);
        1: r = RW'($urandom_range(1, 200));
        2: r = RW'($urandom_range(500, 200000));
        3: r = RW'($urandom) & ((RW'(1) << $urandom_range(1, RW)) - RW'(1));
        default: r = (i % 40 == 0) ? '0 : RW'($urandom_range(2000, 50000));
      endcase
      pending_ohms.push_back(r);
    end
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_resistance_ohms <= '0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_temps.push_back(convert_ohms(in_resistance_ohms));
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ohms.size() > 0) begin
        in_valid <= 1'b1;
        in_resistance_ohms <= pending_ohms.pop_front();
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    temp_result_t exp_t;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_off <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_temps.size() == 0) begin
          $display("%0t: unexpected item neg_temp=%0d invalid=%0b", $realtime,
                   out_neg_temperature, out_invalid);
          errors++;
        end else begin
          exp_t = expected_temps.pop_front();
          if (exp_t.neg_temp !== out_neg_temperature) begin
            $display("%0t: neg_temperature expected %0d actual %0d", $realtime,
                     exp_t.neg_temp, out_neg_temperature);
            errors++;
          end
          if (exp_t.invalid !== out_invalid) begin
            $display("%0t: invalid expected %0b actual %0b", $realtime,
                     exp_t.invalid, out_invalid);
            errors++;
          end
        end
      end
      hold_off <= hold_off + 1;
      if (hold_off >= 300 && hold_off < 500) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_ohms.size() > 0 || in_valid || expected_temps.size() > 0)
      @(negedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_temps.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
